### design/ffla_pkg.sv
// ----------------------------------------------------------------------------
// ffla_pkg
// Shared types and constants for the free-list chunk allocator: header
// layout, status codes, sequencer states and the shared adder interface.
// ----------------------------------------------------------------------------
package ffla_pkg;

  localparam int REGION_BYTES = 256;
  localparam int OFF_W        = 8;
  localparam int LEN_W        = 9;
  localparam int CNT_W        = 9;
  localparam int ALU_W        = 10;
  localparam int HDR_W        = 2 + LEN_W;

  localparam logic [LEN_W-1:0] REGION_LEN = LEN_W'(REGION_BYTES);
  localparam logic [CNT_W-1:0] RING_DEPTH = CNT_W'(REGION_BYTES);

  localparam logic [1:0] HDR_UNSET = 2'd0;
  localparam logic [1:0] HDR_BUSY  = 2'd1;
  localparam logic [1:0] HDR_FREE  = 2'd2;

  typedef struct packed {
    logic [1:0]       st;
    logic [LEN_W-1:0] len;
  } hdr_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_ADD_SAT,
    ALU_SUB_SAT
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_POP,
    ST_A_KEY,
    ST_A_HDR,
    ST_A_NB,
    ST_A_CLR,
    ST_A_DEC,
    ST_A_SPL,
    ST_A_REST,
    ST_A_FT,
    ST_F_HDR,
    ST_F_CHK,
    ST_F_NB,
    ST_F_MARK,
    ST_RESP
  } state_e;

endpackage

### design/ffla_ram.sv
// ----------------------------------------------------------------------------
// ffla_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ffla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ffla_alu.sv
// ----------------------------------------------------------------------------
// ffla_alu
// Shared add/subtract unit with saturation, reused by several steps of the
// allocator sequencer.
// ----------------------------------------------------------------------------
module ffla_alu import ffla_pkg::*; (
  input  alu_req_t         req_i,
  output logic [ALU_W-1:0] y_o
);

  localparam logic [ALU_W:0] SAT = (ALU_W+1)'(REGION_BYTES);

  logic [ALU_W:0] sum;

  assign sum = {1'b0, req_i.a} + {1'b0, req_i.b};

  always_comb begin
    unique case (req_i.op)
      ALU_ADD:     y_o = sum[ALU_W-1:0];
      ALU_ADD_SAT: y_o = (sum > SAT) ? SAT[ALU_W-1:0] : sum[ALU_W-1:0];
      ALU_SUB_SAT: y_o = (req_i.a >= req_i.b) ? (req_i.a - req_i.b) : '0;
      default:     y_o = '0;
    endcase
  end

endmodule

### design/fifo_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// fifo_free_list_allocator_core
// First-fit chunk allocator with right-neighbor coalescing over a 256-byte
// region; free chunk offsets circulate through a FIFO ring.
// ----------------------------------------------------------------------------
//  channel   dir  transfer when            payload
//  s_axis    in   tvalid & tready          tuser=req_type, tdata=size/offset
//  m_axis    out  tvalid & tready          tuser=granted, tdata=offset/bytes
//
//  Free: header read, neighbor check, neighbor read when needed, then mark.
//  Allocate: pop, key, header, then neighbor read and merge when needed, per
//  ring entry visited, as the header memory has a single read port; then
//  split, rest and free count on a fit; a refused size skips the walk.
//  Reset clears one header valid bit per offset at once; no clearing pass.
//  Hold in the response state while the output register is still full.
// ----------------------------------------------------------------------------
module fifo_free_list_allocator_core import ffla_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // alloc_size[8:0], free_offset[16:9]
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // chunk_offset[7:0], bytes_free[16:8]
  output logic        m_axis_tuser    // granted
);

  state_e state_q, state_d;

  logic [LEN_W-1:0] size_q, size_d;
  logic [OFF_W-1:0] key_q, key_d;
  logic [OFF_W-1:0] nb_q, nb_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [1:0]       st_q, st_d;
  logic             far_q, far_d;
  logic [OFF_W-1:0] head_q, head_d;
  logic [OFF_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rounds_q, rounds_d;
  logic [CNT_W-1:0] iter_q, iter_d;
  logic [LEN_W-1:0] free_q, free_d;
  logic             ring0_q;
  logic             ring_vld_q, ring_vld_d;
  logic [REGION_BYTES-1:0] hvld_q;
  logic             hrd_vld_q;
  logic             hrd_zero_q;
  logic             res_granted_q, res_granted_d;
  logic [OFF_W-1:0] res_offset_q, res_offset_d;
  logic             m_valid_q, m_valid_d;
  logic             m_granted_q, m_granted_d;
  logic [OFF_W-1:0] m_offset_q, m_offset_d;
  logic [LEN_W-1:0] m_bytes_q, m_bytes_d;

  logic             hdr_we, hdr_re;
  logic [OFF_W-1:0] hdr_waddr, hdr_raddr;
  hdr_t             hdr_wdata;
  logic [HDR_W-1:0] hdr_rdata;
  hdr_t             hdr_rd;

  logic             ring_we, ring_re;
  logic [OFF_W-1:0] ring_wdata, ring_rdata;
  logic [OFF_W-1:0] ring_key;

  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_y;

  logic             in_fire;
  logic             out_free;
  logic             far;
  logic             fit;
  logic             push_ok;
  logic             pop_done;
  logic             refuse;

  ffla_ram #(.WIDTH(HDR_W), .DEPTH(REGION_BYTES)) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (hdr_we),
    .waddr_i (hdr_waddr),
    .wdata_i (hdr_wdata),
    .re_i    (hdr_re),
    .raddr_i (hdr_raddr),
    .rdata_o (hdr_rdata)
  );

  ffla_ram #(.WIDTH(OFF_W), .DEPTH(REGION_BYTES)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (tail_q),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  ffla_alu u_alu (
    .req_i (alu_req),
    .y_o   (alu_y)
  );

  always_comb begin
    if (hrd_vld_q) begin
      hdr_rd = hdr_t'(hdr_rdata);
    end else begin
      hdr_rd.st  = HDR_UNSET;
      hdr_rd.len = hrd_zero_q ? REGION_LEN : '0;
    end
  end

  assign ring_key = ring_vld_q ? ring_rdata : '0;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign far      = (alu_req.b == '0) || (alu_y[ALU_W-1:OFF_W] != '0);
  assign fit      = len_q >= size_q;
  assign push_ok  = count_q != RING_DEPTH;
  assign pop_done = (iter_q == rounds_q) || (count_q == '0);
  assign refuse   = (s_axis_tdata[8:0] == '0) || (s_axis_tdata[8:0] > free_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser) begin
            state_d = ST_F_HDR;
          end else if (refuse) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_A_POP;
          end
        end
      end
      ST_A_POP:  state_d = pop_done ? ST_RESP : ST_A_KEY;
      ST_A_KEY:  state_d = ST_A_HDR;
      ST_A_HDR:  state_d = far ? ST_A_DEC : ST_A_NB;
      ST_A_NB:   state_d = (hdr_rd.st == HDR_FREE) ? ST_A_CLR : ST_A_DEC;
      ST_A_CLR:  state_d = ST_A_DEC;
      ST_A_DEC:  state_d = fit ? ST_A_SPL : ST_A_POP;
      ST_A_SPL:  state_d = ST_A_REST;
      ST_A_REST: state_d = ST_A_FT;
      ST_A_FT:   state_d = ST_RESP;
      ST_F_HDR:  state_d = ST_F_CHK;
      ST_F_CHK:  state_d = far ? ST_F_MARK : ST_F_NB;
      ST_F_NB:   state_d = ST_F_MARK;
      ST_F_MARK: state_d = ST_RESP;
      ST_RESP:   state_d = out_free ? ST_IDLE : ST_RESP;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    size_d        = size_q;
    key_d         = key_q;
    nb_d          = nb_q;
    len_d         = len_q;
    st_d          = st_q;
    far_d         = far_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    rounds_d      = rounds_q;
    iter_d        = iter_q;
    free_d        = free_q;
    ring_vld_d    = ring_vld_q;
    res_granted_d = res_granted_q;
    res_offset_d  = res_offset_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_granted_d   = m_granted_q;
    m_offset_d    = m_offset_q;
    m_bytes_d     = m_bytes_q;
    hdr_we        = 1'b0;
    hdr_waddr     = key_q;
    hdr_wdata     = '{st: HDR_FREE, len: len_q};
    hdr_re        = 1'b0;
    hdr_raddr     = key_q;
    ring_we       = 1'b0;
    ring_wdata    = key_q;
    ring_re       = 1'b0;
    alu_req       = '{op: ALU_ADD, a: '0, b: '0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          size_d        = s_axis_tdata[8:0];
          key_d         = s_axis_tdata[16:9];
          rounds_d      = count_q + CNT_W'(1);
          iter_d        = '0;
          res_granted_d = s_axis_tuser;
          res_offset_d  = '0;
          hdr_re        = s_axis_tuser;
          hdr_raddr     = s_axis_tdata[16:9];
        end
      end
      ST_A_POP: begin
        if (!pop_done) begin
          ring_re    = 1'b1;
          ring_vld_d = (head_q != '0) || ring0_q;
          head_d     = head_q + OFF_W'(1);
          count_d    = count_q - CNT_W'(1);
          iter_d     = iter_q + CNT_W'(1);
        end
      end
      ST_A_KEY: begin
        key_d     = ring_key;
        hdr_re    = 1'b1;
        hdr_raddr = ring_key;
      end
      ST_A_HDR: begin
        alu_req   = '{op: ALU_ADD, a: ALU_W'(key_q), b: ALU_W'(hdr_rd.len)};
        len_d     = hdr_rd.len;
        st_d      = hdr_rd.st;
        nb_d      = alu_y[OFF_W-1:0];
        hdr_re    = !far;
        hdr_raddr = alu_y[OFF_W-1:0];
      end
      ST_A_NB: begin
        alu_req = '{op: ALU_ADD_SAT, a: ALU_W'(len_q), b: ALU_W'(hdr_rd.len)};
        if (hdr_rd.st == HDR_FREE) begin
          len_d     = alu_y[LEN_W-1:0];
          hdr_we    = 1'b1;
          hdr_waddr = key_q;
          hdr_wdata = '{st: st_q, len: alu_y[LEN_W-1:0]};
        end
      end
      ST_A_CLR: begin
        hdr_we    = 1'b1;
        hdr_waddr = nb_q;
        hdr_wdata = '{st: HDR_FREE, len: '0};
      end
      ST_A_DEC: begin
        if (!fit && (len_q != '0) && push_ok) begin
          ring_we    = 1'b1;
          ring_wdata = key_q;
          tail_d     = tail_q + OFF_W'(1);
          count_d    = count_q + CNT_W'(1);
        end
      end
      ST_A_SPL: begin
        alu_req   = '{op: ALU_ADD, a: ALU_W'(key_q), b: ALU_W'(size_q)};
        nb_d      = alu_y[OFF_W-1:0];
        far_d     = alu_y[ALU_W-1:OFF_W] != '0;
        hdr_we    = 1'b1;
        hdr_waddr = key_q;
        hdr_wdata = '{st: HDR_BUSY, len: size_q};
      end
      ST_A_REST: begin
        alu_req = '{op: ALU_SUB_SAT, a: ALU_W'(len_q), b: ALU_W'(size_q)};
        if (!far_q) begin
          hdr_we    = 1'b1;
          hdr_waddr = nb_q;
          hdr_wdata = '{st: HDR_FREE, len: alu_y[LEN_W-1:0]};
          if ((alu_y != '0) && push_ok) begin
            ring_we    = 1'b1;
            ring_wdata = nb_q;
            tail_d     = tail_q + OFF_W'(1);
            count_d    = count_q + CNT_W'(1);
          end
        end
      end
      ST_A_FT: begin
        alu_req       = '{op: ALU_SUB_SAT, a: ALU_W'(free_q), b: ALU_W'(size_q)};
        free_d        = alu_y[LEN_W-1:0];
        res_granted_d = 1'b1;
        res_offset_d  = key_q;
      end
      ST_F_HDR: begin
        alu_req = '{op: ALU_ADD_SAT, a: ALU_W'(free_q), b: ALU_W'(hdr_rd.len)};
        len_d   = hdr_rd.len;
        st_d    = hdr_rd.st;
        free_d  = alu_y[LEN_W-1:0];
      end
      ST_F_CHK: begin
        alu_req   = '{op: ALU_ADD, a: ALU_W'(key_q), b: ALU_W'(len_q)};
        nb_d      = alu_y[OFF_W-1:0];
        hdr_re    = !far;
        hdr_raddr = alu_y[OFF_W-1:0];
      end
      ST_F_NB: begin
        alu_req = '{op: ALU_ADD_SAT, a: ALU_W'(len_q), b: ALU_W'(hdr_rd.len)};
        if (hdr_rd.st == HDR_FREE) begin
          len_d     = alu_y[LEN_W-1:0];
          hdr_we    = 1'b1;
          hdr_waddr = nb_q;
          hdr_wdata = '{st: HDR_FREE, len: '0};
        end
      end
      ST_F_MARK: begin
        hdr_we    = 1'b1;
        hdr_waddr = key_q;
        hdr_wdata = '{st: HDR_FREE, len: len_q};
        if (push_ok) begin
          ring_we    = 1'b1;
          ring_wdata = key_q;
          tail_d     = tail_q + OFF_W'(1);
          count_d    = count_q + CNT_W'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          m_valid_d   = 1'b1;
          m_granted_d = res_granted_q;
          m_offset_d  = res_offset_q;
          m_bytes_d   = free_q;
        end
      end
      default: begin
        m_valid_d = m_valid_q && !m_axis_tready;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      tail_q    <= OFF_W'(1);
      count_q   <= CNT_W'(1);
      free_q    <= REGION_LEN;
      ring0_q   <= 1'b0;
      hvld_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      free_q    <= free_d;
      m_valid_q <= m_valid_d;
      if (ring_we && (tail_q == '0)) begin
        ring0_q <= 1'b1;
      end
      if (hdr_we) begin
        hvld_q[hdr_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size_q        <= size_d;
    key_q         <= key_d;
    nb_q          <= nb_d;
    len_q         <= len_d;
    st_q          <= st_d;
    far_q         <= far_d;
    rounds_q      <= rounds_d;
    iter_q        <= iter_d;
    ring_vld_q    <= ring_vld_d;
    res_granted_q <= res_granted_d;
    res_offset_q  <= res_offset_d;
    m_granted_q   <= m_granted_d;
    m_offset_q    <= m_offset_d;
    m_bytes_q     <= m_bytes_d;
    if (hdr_re) begin
      hrd_vld_q  <= hvld_q[hdr_raddr];
      hrd_zero_q <= hdr_raddr == '0;
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_bytes_q, m_offset_q};
  assign m_axis_tuser  = m_granted_q;

`ifndef ASSERT_OFF
  a_ring_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= RING_DEPTH)
    else $error("ring count exceeds ring depth");

  a_free_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= REGION_LEN)
    else $error("free byte count exceeds region size");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("request taken while a request is in progress");

  a_hdr_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_we && hdr_re) |-> (hdr_waddr != hdr_raddr))
    else $error("header read and write hit the same offset");
`endif

endmodule
